@@ src/positional_sequence_store_defines.svh @@
// Assertion macros used by the positional sequence store datapath.
// No dependencies; include with the bare file name.
`ifndef POSITIONAL_SEQUENCE_STORE_DEFINES_SVH
`define POSITIONAL_SEQUENCE_STORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Property must hold at every rising clock edge outside reset.
`define PSS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("pss assertion failed");
// Expression must never be true outside reset.
`define PSS_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("pss forbidden condition");
`else
`define PSS_ASSERT(lbl, clk, rst, prop)
`define PSS_NEVER(lbl, clk, rst, expr)
`endif

`endif

@@ src/pss_pkg.sv @@
// Shared types and constants of the positional sequence store.
// No dependencies.
package pss_pkg;

  localparam int OP_W   = 2;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 64;
  localparam int STAT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_DUMP   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } stat_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  load_status;
    stat_t stat;
    logic  do_insert;
    logic  do_remove;
    logic  dump_start;
    logic  do_rotate;
    logic  out_pop;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic rm_bad;
    logic empty;
    logic dump_last;
    logic out_valid;
  } sts_t;

endpackage

@@ src/pss_ctrl.sv @@
// Controller of the positional sequence store: request handshake and dump sequencing.
// Depends on pss_pkg.
module pss_ctrl
  import pss_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [OP_W-1:0] opcode,
  input  logic            out_stall,
  input  sts_t            sts,
  output cmd_t            cmd
);

  state_t state, state_next;
  logic   slot_free;
  logic   accept;

  assign slot_free = !sts.out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.stat      = STAT_OK;
    cmd.out_pop   = sts.out_valid && !out_stall;
    in_stall      = 1'b1;
    accept        = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall = !slot_free;
        accept   = in_valid && slot_free;
        if (accept) begin
          unique case (op_t'(opcode))
            OP_INSERT: begin
              cmd.load_status = 1'b1;
              if (sts.full) begin
                cmd.stat = STAT_FULL;
              end else begin
                cmd.do_insert = 1'b1;
              end
            end
            OP_REMOVE: begin
              cmd.load_status = 1'b1;
              if (sts.rm_bad) begin
                cmd.stat = STAT_RANGE;
              end else begin
                cmd.do_remove = 1'b1;
              end
            end
            OP_DUMP: begin
              if (sts.empty) begin
                cmd.load_status = 1'b1;
              end else begin
                cmd.dump_start = 1'b1;
                state_next     = S_DUMP;
              end
            end
            OP_NONE: begin
              // drop the request, no result
            end
          endcase
        end
      end
      S_DUMP: begin
        if (slot_free) begin
          cmd.do_rotate = 1'b1;
          if (sts.dump_last) begin
            state_next = S_IDLE;
          end
        end
      end
    endcase
  end

endmodule

@@ src/pss_datapath.sv @@
// Datapath of the positional sequence store: shifting cell row, count, result register.
// Depends on pss_pkg and positional_sequence_store_defines.svh.
`include "positional_sequence_store_defines.svh"
module pss_datapath
  import pss_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  input  logic [POS_W-1:0]        position,
  input  logic signed [VAL_W-1:0] value,
  output logic [STAT_W-1:0]       status,
  output logic [POS_W-1:0]        length,
  output logic signed [VAL_W-1:0] element,
  output logic                    element_valid,
  output logic                    last,
  output logic                    out_valid
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [VAL_W-1:0] cells [CAPACITY];
  logic [CW-1:0]           count, count_next;
  logic [CW-1:0]           dump_idx;
  logic [POS_W-1:0]        cnt7;
  logic [POS_W-1:0]        ins_pos;
  logic [POS_W-1:0]        rm_pos;

  assign cnt7    = POS_W'(count);
  assign ins_pos = (position > cnt7) ? cnt7 : position;
  assign rm_pos  = position - POS_W'(1);

  assign sts.full      = count >= CW'(CAPACITY);
  assign sts.rm_bad    = (position == '0) || (position > cnt7);
  assign sts.empty     = count == '0;
  assign sts.dump_last = CW'(dump_idx + CW'(1)) == count;
  assign sts.out_valid = out_valid;

  always_comb begin
    count_next = count;
    if (cmd.do_insert) begin
      count_next = count + CW'(1);
    end else if (cmd.do_remove) begin
      count_next = count - CW'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [POS_W-1:0] IDX   = POS_W'(i);
    localparam logic [POS_W-1:0] IDX_N = POS_W'(i + 1);
    logic signed [VAL_W-1:0] prev_c;
    logic signed [VAL_W-1:0] next_c;

    if (i == 0) begin : g_first
      assign prev_c = '0;
    end else begin : g_prev
      assign prev_c = cells[i-1];
    end
    if (i == CAPACITY - 1) begin : g_final
      assign next_c = '0;
    end else begin : g_next
      assign next_c = cells[i+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.do_insert) begin
        // open a gap at the insert point, shift the tail up
        if (IDX == ins_pos) begin
          cells[i] <= value;
        end else if (IDX > ins_pos && IDX <= cnt7) begin
          cells[i] <= prev_c;
        end
      end else if (cmd.do_remove) begin
        // close the gap, shift the tail down
        if (IDX >= rm_pos && IDX_N < cnt7) begin
          cells[i] <= next_c;
        end
      end else if (cmd.do_rotate) begin
        // rotate the live part so the head wraps to the tail
        if (IDX_N < cnt7) begin
          cells[i] <= next_c;
        end else if (IDX_N == cnt7) begin
          cells[i] <= cells[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      dump_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (cmd.dump_start) begin
        dump_idx <= '0;
      end else if (cmd.do_rotate) begin
        dump_idx <= dump_idx + CW'(1);
      end
      if (cmd.load_status || cmd.do_rotate) begin
        out_valid <= 1'b1;
      end else if (cmd.out_pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_status) begin
      status        <= cmd.stat;
      length        <= POS_W'(count_next);
      element       <= '0;
      element_valid <= 1'b0;
      last          <= 1'b1;
    end else if (cmd.do_rotate) begin
      status        <= STAT_OK;
      length        <= cnt7;
      element       <= cells[0];
      element_valid <= 1'b1;
      last          <= sts.dump_last;
    end
  end

  `PSS_ASSERT(a_insert_grows, clk, rst, cmd.do_insert |=> count == $past(count) + CW'(1))
  `PSS_ASSERT(a_remove_shrinks, clk, rst, cmd.do_remove |=> count == $past(count) - CW'(1))
  `PSS_NEVER(a_no_insert_full, clk, rst, cmd.do_insert && sts.full)

endmodule

@@ src/positional_sequence_store.sv @@
// Positional sequence store: ordered list of signed 64-bit values in a row of shifting cells.
// Insert and remove update the cells and count; the status result is registered and visible next cycle.
// Dump: start step, then one element per cell rotation; empty store gives status result only.
// Outside a dump, a request is taken whenever the result register is empty or draining.
// Reset (synchronous, rst high) empties the store; cell contents are not cleared.
// Depends on pss_pkg, pss_ctrl, pss_datapath and positional_sequence_store_defines.svh.
module positional_sequence_store
  import pss_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  // request channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OP_W-1:0]         opcode,
  input  logic [POS_W-1:0]        position,
  input  logic signed [VAL_W-1:0] value,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [STAT_W-1:0]       status,
  output logic [POS_W-1:0]        length,
  output logic signed [VAL_W-1:0] element,
  output logic                    element_valid,
  output logic                    last
);

  cmd_t cmd;
  sts_t sts;

  // Controller: accepts requests, decides status, sequences a dump.
  pss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: cells shift in parallel on insert/remove and rotate on dump;
  // the result register holds the outgoing request result.
  pss_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .position      (position),
    .value         (value),
    .status        (status),
    .length        (length),
    .element       (element),
    .element_valid (element_valid),
    .last          (last),
    .out_valid     (out_valid)
  );

endmodule
